FILE: hw/rtl/tss_pkg.sv
`timescale 1ns / 1ps

package tss_pkg;

    localparam int COORD_BITS = 12;
    localparam int SCREEN_BITS = 11;
    localparam int PLANE_BITS = 3;
    localparam int COLOUR_BITS = 8;
    localparam int PBC_BITS = 32;
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    localparam logic [1:0] REG_SCREEN_WIDTH = 2'd0;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PLANE_BIT_COUNTS = 2'd2;

    localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RST = 11'd640;
    localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RST = 11'd480;
    localparam logic [PBC_BITS-1:0] PLANE_BIT_COUNTS_RST = 32'h1111_1111;

endpackage

FILE: hw/rtl/tss_div_pipe.sv
`timescale 1ns / 1ps

// Two-lane restoring divider, one quotient bit per stage, sideband carried along.
module tss_div_pipe #(
    parameter int NW = 25,
    parameter int DW = 13,
    parameter int SW = 38
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [NW-1:0] i_num_a,
    input  logic [DW-1:0] i_den_a,
    input  logic [NW-1:0] i_num_b,
    input  logic [DW-1:0] i_den_b,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [NW-1:0] o_quo_a,
    output logic [NW-1:0] o_quo_b,
    output logic [SW-1:0] o_side
);

    logic [NW-1:0]                 r_v;
    logic [NW:0]                   en;
    logic [NW-1:0][NW-1:0]         r_num_a;
    logic [NW-1:0][NW-1:0]         r_num_b;
    logic [NW-1:0][DW-1:0]         r_rem_a;
    logic [NW-1:0][DW-1:0]         r_rem_b;
    logic [NW-1:0][DW-1:0]         r_den_a;
    logic [NW-1:0][DW-1:0]         r_den_b;
    logic [NW-1:0][SW-1:0]         r_side;

    assign en[NW] = !i_stall;

    genvar gi;
    generate
        for (gi = 0; gi < NW; gi++) begin : g_stage
            logic          p_v;
            logic [NW-1:0] p_num_a;
            logic [NW-1:0] p_num_b;
            logic [DW-1:0] p_rem_a;
            logic [DW-1:0] p_rem_b;
            logic [DW-1:0] p_den_a;
            logic [DW-1:0] p_den_b;
            logic [SW-1:0] p_side;
            logic [DW:0]   t_a;
            logic [DW:0]   t_b;
            logic [DW:0]   d_a;
            logic [DW:0]   d_b;
            logic          ge_a;
            logic          ge_b;
            logic [DW:0]   s_a;
            logic [DW:0]   s_b;

            if (gi == 0) begin : g_first
                assign p_v = i_valid;
                assign p_num_a = i_num_a;
                assign p_num_b = i_num_b;
                assign p_rem_a = '0;
                assign p_rem_b = '0;
                assign p_den_a = i_den_a;
                assign p_den_b = i_den_b;
                assign p_side = i_side;
            end else begin : g_next
                assign p_v = r_v[gi-1];
                assign p_num_a = r_num_a[gi-1];
                assign p_num_b = r_num_b[gi-1];
                assign p_rem_a = r_rem_a[gi-1];
                assign p_rem_b = r_rem_b[gi-1];
                assign p_den_a = r_den_a[gi-1];
                assign p_den_b = r_den_b[gi-1];
                assign p_side = r_side[gi-1];
            end

            assign en[gi] = !r_v[gi] || en[gi+1];

            always_comb begin
                t_a = {p_rem_a, p_num_a[NW-1]};
                t_b = {p_rem_b, p_num_b[NW-1]};
                d_a = {1'b0, p_den_a};
                d_b = {1'b0, p_den_b};
                ge_a = t_a >= d_a;
                ge_b = t_b >= d_b;
                s_a = ge_a ? (t_a - d_a) : t_a;
                s_b = ge_b ? (t_b - d_b) : t_b;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[gi] <= 1'b0;
                end else if (en[gi]) begin
                    r_v[gi] <= p_v;
                end
                if (en[gi]) begin
                    r_num_a[gi] <= {p_num_a[NW-2:0], ge_a};
                    r_num_b[gi] <= {p_num_b[NW-2:0], ge_b};
                    r_rem_a[gi] <= s_a[DW-1:0];
                    r_rem_b[gi] <= s_b[DW-1:0];
                    r_den_a[gi] <= p_den_a;
                    r_den_b[gi] <= p_den_b;
                    r_side[gi] <= p_side;
                end
            end
        end
    endgenerate

    assign o_stall = !en[0];
    assign o_valid = r_v[NW-1];
    assign o_quo_a = r_num_a[NW-1];
    assign o_quo_b = r_num_b[NW-1];
    assign o_side = r_side[NW-1];

endmodule

FILE: hw/rtl/triangle_scanline_span.sv
`timescale 1ns / 1ps

// Scanline span generator: takes one triangle and one row a cycle unless the input is
// stalled, and returns the span of that row covered by the triangle, plus the colour
// byte for the chosen bit plane. The divider is pipelined and resolves one quotient bit
// per stage for both triangle edges at once. A stalled output holds the pipeline only
// as far back as there are no empty stages.
module triangle_scanline_span #(
    parameter int COORD_BITS = tss_pkg::COORD_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tss_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [tss_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [tss_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [COORD_BITS-1:0]        i_v1_x,
    input  logic signed [COORD_BITS-1:0]        i_v1_y,
    input  logic signed [COORD_BITS-1:0]        i_v2_x,
    input  logic signed [COORD_BITS-1:0]        i_v2_y,
    input  logic signed [COORD_BITS-1:0]        i_v3_x,
    input  logic signed [COORD_BITS-1:0]        i_v3_y,
    input  logic [tss_pkg::SCREEN_BITS-1:0]     i_row,
    input  logic [tss_pkg::PLANE_BITS-1:0]      i_plane_sel,
    input  logic [tss_pkg::COLOUR_BITS-1:0]     i_colour,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_row_active,
    output logic                                o_drawn,
    output logic [tss_pkg::SCREEN_BITS-1:0]     o_span_start,
    output logic [tss_pkg::SCREEN_BITS-1:0]     o_span_width,
    output logic [tss_pkg::COLOUR_BITS-1:0]     o_pixel_byte,
    output logic [tss_pkg::PLANE_BITS-1:0]      o_plane_out
);

    localparam int CB = COORD_BITS;
    localparam int SB = tss_pkg::SCREEN_BITS;
    localparam int PB = tss_pkg::PLANE_BITS;
    localparam int KB = tss_pkg::COLOUR_BITS;
    localparam int RB = ((CB - 1 > SB) ? CB - 1 : SB) + 1;
    localparam int CW = ((CB > SB) ? CB : SB) + 2;
    localparam int DW = CB + 1;
    localparam int PW = RB + CB + 1;
    localparam int XW = PW + 2;
    localparam int SW = 2 * CB + 3 + KB + PB;

    // ---------------- configuration ----------------
    logic [SB-1:0] r_screen_width;
    logic [SB-1:0] r_screen_height;
    logic [31:0]   r_plane_bit_counts;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width <= tss_pkg::SCREEN_WIDTH_RST;
            r_screen_height <= tss_pkg::SCREEN_HEIGHT_RST;
            r_plane_bit_counts <= tss_pkg::PLANE_BIT_COUNTS_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                tss_pkg::REG_SCREEN_WIDTH: r_screen_width <= pwdata[SB-1:0];
                tss_pkg::REG_SCREEN_HEIGHT: r_screen_height <= pwdata[SB-1:0];
                tss_pkg::REG_PLANE_BIT_COUNTS: r_plane_bit_counts <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            tss_pkg::REG_SCREEN_WIDTH: prdata = {21'd0, r_screen_width};
            tss_pkg::REG_SCREEN_HEIGHT: prdata = {21'd0, r_screen_height};
            tss_pkg::REG_PLANE_BIT_COUNTS: prdata = r_plane_bit_counts;
            default: prdata = '0;
        endcase
    end

    // ---------------- handshake chain ----------------
    logic en_a, en_b, en_c, en_e, en_f;
    logic div_stall, div_valid;
    logic r_va, r_vb, r_vc, r_ve, r_vf;

    assign en_f = !r_vf || !i_out_stall;
    assign en_e = !r_ve || en_f;
    assign en_c = !r_vc || !div_stall;
    assign en_b = !r_vb || en_c;
    assign en_a = !r_va || en_b;
    assign o_in_stall = !en_a;

    // ---------------- stage A: sort vertices by y ----------------
    logic signed [CB-1:0] s_xa, s_ya, s_xb, s_yb, s_xc, s_yc;
    logic signed [CB-1:0] t_xa, t_ya, t_xb, t_yb, t_xc, t_yc;
    logic signed [CB-1:0] r_xa, r_ya, r_xb, r_yb, r_xc, r_yc;
    logic [SB-1:0]        r_row_a;
    logic [PB-1:0]        r_plane_a;
    logic [KB-1:0]        r_colour_a;

    always_comb begin
        if (i_v1_y < i_v2_y) begin
            t_xa = i_v1_x; t_ya = i_v1_y; t_xb = i_v2_x; t_yb = i_v2_y;
        end else begin
            t_xa = i_v2_x; t_ya = i_v2_y; t_xb = i_v1_x; t_yb = i_v1_y;
        end
        t_xc = i_v3_x; t_yc = i_v3_y;
        if (t_yb > t_yc) begin
            s_xb = t_xc; s_yb = t_yc; s_xc = t_xb; s_yc = t_yb;
        end else begin
            s_xb = t_xb; s_yb = t_yb; s_xc = t_xc; s_yc = t_yc;
        end
        s_xa = t_xa; s_ya = t_ya;
        if (s_ya > s_yb) begin
            s_xa = s_xb; s_ya = s_yb; s_xb = t_xa; s_yb = t_ya;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (en_a) begin
            r_va <= i_in_valid;
        end
        if (en_a) begin
            r_xa <= s_xa; r_ya <= s_ya;
            r_xb <= s_xb; r_yb <= s_yb;
            r_xc <= s_xc; r_yc <= s_yc;
            r_row_a <= i_row;
            r_plane_a <= i_plane_sel;
            r_colour_a <= i_colour;
        end
    end

    // ---------------- stage B: row range, edge terms, plane byte ----------------
    logic signed [CW-1:0] row_s, ya_w, yb_w, yc_w, h_w, hm1_w, ylo_c, yhi_c, ry0, ry1;
    logic                 act_b, upper;
    logic signed [CB-1:0] x0s, x1s, y0s, y1s;
    logic signed [RB:0]   nl_s, ns_s;
    logic signed [CB+1:0] dxl_s, dxs_s, dxl_w, dxs_w, dyl_w, dys_w;
    logic [RB-1:0]        nl_m, ns_m;
    logic [CB:0]          dxl_m, dxs_m;
    logic [6:0]           offs;
    logic [15:0]          sh;
    logic [KB-1:0]        pbyte;

    always_comb begin
        row_s = CW'(signed'({1'b0, r_row_a}));
        ya_w = CW'(r_ya);
        yb_w = CW'(r_yb);
        yc_w = CW'(r_yc);
        h_w = CW'(signed'({1'b0, r_screen_height}));
        hm1_w = h_w - CW'(1);
        ylo_c = (ya_w < 0) ? '0 : ya_w;
        yhi_c = (yc_w < 0) ? '0 : yc_w;
        ry0 = (ylo_c < h_w) ? ylo_c : hm1_w;
        ry1 = (yhi_c < h_w) ? yhi_c : hm1_w;
        act_b = (r_ya < r_yc) && (row_s >= ry0) && (row_s <= ry1);

        upper = row_s < yb_w;
        x0s = upper ? r_xa : r_xb;
        y0s = upper ? r_ya : r_yb;
        x1s = upper ? r_xb : r_xc;
        y1s = upper ? r_yb : r_yc;

        nl_s = (RB+1)'(signed'({1'b0, r_row_a})) - (RB+1)'(r_ya);
        ns_s = (RB+1)'(signed'({1'b0, r_row_a})) - (RB+1)'(y0s);
        dxl_w = (CB+2)'(r_xc) - (CB+2)'(r_xa);
        dxs_w = (CB+2)'(x1s) - (CB+2)'(x0s);
        // widen the x delta by one away from zero
        dxl_s = dxl_w[CB+1] ? dxl_w - (CB+2)'(1) : dxl_w + (CB+2)'(1);
        dxs_s = dxs_w[CB+1] ? dxs_w - (CB+2)'(1) : dxs_w + (CB+2)'(1);
        dyl_w = (CB+2)'(r_yc) - (CB+2)'(r_ya) + (CB+2)'(1);
        dys_w = (CB+2)'(y1s) - (CB+2)'(y0s) + (CB+2)'(1);

        nl_m = nl_s[RB] ? RB'(-nl_s) : nl_s[RB-1:0];
        ns_m = ns_s[RB] ? RB'(-ns_s) : ns_s[RB-1:0];
        dxl_m = dxl_s[CB+1] ? (CB+1)'(-dxl_s) : dxl_s[CB:0];
        dxs_m = dxs_s[CB+1] ? (CB+1)'(-dxs_s) : dxs_s[CB:0];

        offs = '0;
        for (int i = 0; i < 7; i++) begin
            if (3'(i) < r_plane_a) begin
                offs = offs + 7'(r_plane_bit_counts[4*i +: 4]);
            end
        end
        sh = {8'd0, r_colour_a} << offs[2:0];
        pbyte = (offs < 7'd8) ? sh[KB-1:0] : '0;
    end

    logic                 r_act_b, r_negl_b, r_negs_b;
    logic [RB-1:0]        r_nl_b, r_ns_b;
    logic [CB:0]          r_dxl_b, r_dxs_b;
    logic [DW-1:0]        r_dyl_b, r_dys_b;
    logic signed [CB-1:0] r_xa_b, r_x0s_b;
    logic [KB-1:0]        r_pbyte_b;
    logic [PB-1:0]        r_plane_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (en_b) begin
            r_vb <= r_va;
        end
        if (en_b) begin
            r_act_b <= act_b;
            r_negl_b <= nl_s[RB] ^ dxl_s[CB+1];
            r_negs_b <= ns_s[RB] ^ dxs_s[CB+1];
            r_nl_b <= nl_m;
            r_ns_b <= ns_m;
            r_dxl_b <= dxl_m;
            r_dxs_b <= dxs_m;
            r_dyl_b <= dyl_w[DW-1:0];
            r_dys_b <= dys_w[DW-1:0];
            r_xa_b <= r_xa;
            r_x0s_b <= x0s;
            r_pbyte_b <= pbyte;
            r_plane_b <= r_plane_a;
        end
    end

    // ---------------- stage C: products ----------------
    logic [PW-1:0]   r_pl_c, r_ps_c;
    logic [DW-1:0]   r_dyl_c, r_dys_c;
    logic [SW-1:0]   r_side_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else if (en_c) begin
            r_vc <= r_vb;
        end
        if (en_c) begin
            r_pl_c <= PW'(r_nl_b) * PW'(r_dxl_b);
            r_ps_c <= PW'(r_ns_b) * PW'(r_dxs_b);
            r_dyl_c <= r_dyl_b;
            r_dys_c <= r_dys_b;
            r_side_c <= {r_act_b, r_xa_b, r_x0s_b, r_negl_b, r_negs_b, r_pbyte_b, r_plane_b};
        end
    end

    // ---------------- divider ----------------
    logic [PW-1:0] ql, qs;
    logic [SW-1:0] side_d;

    tss_div_pipe #(
        .NW(PW),
        .DW(DW),
        .SW(SW)
    ) u_div (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(r_vc),
        .o_stall(div_stall),
        .i_num_a(r_pl_c),
        .i_den_a(r_dyl_c),
        .i_num_b(r_ps_c),
        .i_den_b(r_dys_c),
        .i_side(r_side_c),
        .o_valid(div_valid),
        .i_stall(!en_e),
        .o_quo_a(ql),
        .o_quo_b(qs),
        .o_side(side_d)
    );

    // ---------------- stage E: edge x values ----------------
    logic                 d_act, d_negl, d_negs;
    logic signed [CB-1:0] d_xa, d_x0s;
    logic [KB-1:0]        d_pbyte;
    logic [PB-1:0]        d_plane;
    logic signed [XW-1:0] xl_e, xs_e;

    always_comb begin
        {d_act, d_xa, d_x0s, d_negl, d_negs, d_pbyte, d_plane} = side_d;
        xl_e = d_negl ? XW'(d_xa) - XW'({2'b00, ql}) : XW'(d_xa) + XW'({2'b00, ql});
        xs_e = d_negs ? XW'(d_x0s) - XW'({2'b00, qs}) : XW'(d_x0s) + XW'({2'b00, qs});
    end

    logic                 r_act_e;
    logic signed [XW-1:0] r_xl_e, r_xs_e;
    logic [KB-1:0]        r_pbyte_e;
    logic [PB-1:0]        r_plane_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ve <= 1'b0;
        end else if (en_e) begin
            r_ve <= div_valid;
        end
        if (en_e) begin
            r_act_e <= d_act;
            r_xl_e <= xl_e;
            r_xs_e <= xs_e;
            r_pbyte_e <= d_pbyte;
            r_plane_e <= d_plane;
        end
    end

    // ---------------- stage F: span and output register ----------------
    logic signed [XW-1:0] lo, hi, wlim, wd;
    logic                 drawn_f;

    always_comb begin
        lo = (r_xl_e < r_xs_e) ? r_xl_e : r_xs_e;
        hi = (r_xl_e < r_xs_e) ? r_xs_e : r_xl_e;
        wlim = XW'(signed'({1'b0, r_screen_width}));
        wd = hi - lo;
        drawn_f = r_act_e && (hi > lo) && (lo >= 0) && (hi < wlim);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= 1'b0;
        end else if (en_f) begin
            r_vf <= r_ve;
        end
        if (en_f) begin
            o_row_active <= r_act_e;
            o_drawn <= drawn_f;
            o_span_start <= drawn_f ? lo[SB-1:0] : '0;
            o_span_width <= drawn_f ? wd[SB-1:0] : '0;
            o_pixel_byte <= r_pbyte_e;
            o_plane_out <= r_plane_e;
        end
    end

    assign o_out_valid = r_vf;

    // ---------------- assertions ----------------
    a_drawn_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_drawn) |-> o_row_active)
        else $error("drawn span on inactive row");

    a_empty_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_drawn) |-> (o_span_start == '0 && o_span_width == '0))
        else $error("undrawn span carries nonzero geometry");

    a_drawn_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_drawn) |-> (o_span_width != '0))
        else $error("drawn span has zero width");

    a_no_bubble_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_va && !r_vb) |-> !o_in_stall)
        else $error("input stalled while front stages are empty");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import tss_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int LATENCY = 40;

    typedef struct packed {
        logic signed [CB-1:0] v1_x, v1_y, v2_x, v2_y, v3_x, v3_y;
        logic [SCREEN_BITS-1:0] row;
        logic [PLANE_BITS-1:0] plane_sel;
        logic [COLOUR_BITS-1:0] colour;
    } tri_req_t;

    typedef struct packed {
        logic row_active;
        logic drawn;
        logic [SCREEN_BITS-1:0] span_start;
        logic [SCREEN_BITS-1:0] span_width;
        logic [COLOUR_BITS-1:0] pixel_byte;
        logic [PLANE_BITS-1:0] plane_out;
    } span_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic pready;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    tri_req_t req = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    span_t got;

    logic [SCREEN_BITS-1:0] cfg_width = SCREEN_WIDTH_RST;
    logic [SCREEN_BITS-1:0] cfg_height = SCREEN_HEIGHT_RST;
    logic [PBC_BITS-1:0] cfg_planes = PLANE_BIT_COUNTS_RST;

    span_t expected_spans[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;

    always #5 i_clk = ~i_clk;

    triangle_scanline_span u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_v1_x(req.v1_x), .i_v1_y(req.v1_y), .i_v2_x(req.v2_x),
        .i_v2_y(req.v2_y), .i_v3_x(req.v3_x), .i_v3_y(req.v3_y),
        .i_row(req.row), .i_plane_sel(req.plane_sel), .i_colour(req.colour),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_row_active(got.row_active), .o_drawn(got.drawn),
        .o_span_start(got.span_start), .o_span_width(got.span_width),
        .o_pixel_byte(got.pixel_byte), .o_plane_out(got.plane_out)
    );

    function automatic longint edge_at(longint x0, longint y0, longint x1, longint y1,
                                       longint r);
        longint dx;
        longint dy;
        dx = (x1 - x0 >= 0) ? x1 - x0 + 1 : x1 - x0 - 1;
        dy = y1 - y0 + 1;
        if (dy == 0) return dx + x0;
        return (r - y0) * dx / dy + x0;
    endfunction

    function automatic longint clamp_y(longint y, longint h);
        if (y < 0) y = 0;
        return (y < h) ? y : h - 1;
    endfunction

    function automatic span_t predict_span(tri_req_t t);
        span_t s;
        longint px[3], py[3];
        int a, b, c, k;
        longint r, y0, y1, xl, xs, lo, hi;
        int offs;
        s = '0;
        px[0] = t.v1_x; py[0] = t.v1_y;
        px[1] = t.v2_x; py[1] = t.v2_y;
        px[2] = t.v3_x; py[2] = t.v3_y;
        if (py[0] < py[1]) begin a = 0; b = 1; end else begin a = 1; b = 0; end
        c = 2;
        if (py[b] > py[c]) begin k = b; b = c; c = k; end
        if (py[a] > py[b]) begin k = a; a = b; b = k; end
        r = t.row;
        y0 = clamp_y(py[a], cfg_height);
        y1 = clamp_y(py[c], cfg_height);
        if (py[a] < py[c] && r >= y0 && r <= y1) begin
            s.row_active = 1'b1;
            xl = edge_at(px[a], py[a], px[c], py[c], r);
            if (r < py[b]) xs = edge_at(px[a], py[a], px[b], py[b], r);
            else xs = edge_at(px[b], py[b], px[c], py[c], r);
            lo = (xl < xs) ? xl : xs;
            hi = (xl < xs) ? xs : xl;
            if (hi > lo && lo >= 0 && hi < longint'(cfg_width)) begin
                s.drawn = 1'b1;
                s.span_start = lo[SCREEN_BITS-1:0];
                s.span_width = SCREEN_BITS'(hi - lo);
            end
        end
        offs = 0;
        for (int i = 0; i < t.plane_sel; i++) offs += cfg_planes[4*i +: 4];
        s.pixel_byte = (offs < 8) ? COLOUR_BITS'({8'd0, t.colour} << offs) : '0;
        s.plane_out = t.plane_sel;
        return s;
    endfunction

    task automatic report_mismatch(string what, longint exp_v, longint got_v);
        $display("mismatch %s: expected %0d got %0d", what, exp_v, got_v);
        errors++;
    endtask

    // output side: stall policy and checking
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        span_t e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_spans.size() == 0) begin
                report_mismatch("unexpected result", 0, 1);
            end else begin
                e = expected_spans.pop_front();
                if (got.row_active !== e.row_active)
                    report_mismatch("row_active", e.row_active, got.row_active);
                if (got.drawn !== e.drawn) report_mismatch("drawn", e.drawn, got.drawn);
                if (got.span_start !== e.span_start)
                    report_mismatch("span_start", e.span_start, got.span_start);
                if (got.span_width !== e.span_width)
                    report_mismatch("span_width", e.span_width, got.span_width);
                if (got.pixel_byte !== e.pixel_byte)
                    report_mismatch("pixel_byte", e.pixel_byte, got.pixel_byte);
                if (got.plane_out !== e.plane_out)
                    report_mismatch("plane_out", e.plane_out, got.plane_out);
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= APB_ADDR_BITS'({idx, 2'b00}); pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_SCREEN_WIDTH: cfg_width = value[SCREEN_BITS-1:0];
            REG_SCREEN_HEIGHT: cfg_height = value[SCREEN_BITS-1:0];
            default: cfg_planes = value;
        endcase
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic drain_results();
        while (expected_spans.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    // hold valid across back-to-back requests; drop it only on idle cycles
    task automatic send_request(tri_req_t t, bit check_fixed, span_t fixed);
        span_t p;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        req <= t;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        p = predict_span(t);
        if (check_fixed && p !== fixed) report_mismatch("predictor row", fixed, p);
        expected_spans.push_back(p);
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    function automatic logic signed [CB-1:0] rand_coord(int mode);
        case (mode)
            0: return CB'($urandom());
            1: return CB'($urandom_range(700));
            default: return CB'(int'($urandom_range(200)) - 100);
        endcase
    endfunction

    function automatic tri_req_t rand_request(int mode);
        tri_req_t t;
        t.v1_x = rand_coord(mode); t.v1_y = rand_coord(mode);
        t.v2_x = rand_coord(mode); t.v2_y = rand_coord(mode);
        t.v3_x = rand_coord(mode); t.v3_y = rand_coord(mode);
        if (mode == 0) t.row = SCREEN_BITS'($urandom());
        else t.row = SCREEN_BITS'($urandom_range(600));
        t.plane_sel = PLANE_BITS'($urandom());
        t.colour = COLOUR_BITS'($urandom());
        return t;
    endfunction

    typedef struct {
        tri_req_t t;
        bit check;
        span_t s;
    } dir_row_t;

    dir_row_t directed[] = '{
        // plain triangle, row through middle
        '{'{12'sd10, 12'sd0, 12'sd100, 12'sd50, 12'sd10, 12'sd100, 11'd50, 3'd0, 8'hff},
          1'b0, '0},
        // flat: inactive, plane 1 shifts by one
        '{'{12'sd0, 12'sd5, 12'sd9, 12'sd5, 12'sd3, 12'sd5, 11'd5, 3'd1, 8'h81},
          1'b1, '{1'b0, 1'b0, 11'd0, 11'd0, 8'h02, 3'd1}},
        // plane 7 shifts by seven
        '{'{12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 11'd0, 3'd7, 8'hff},
          1'b1, '{1'b0, 1'b0, 11'd0, 11'd0, 8'h80, 3'd7}},
        // wholly above screen: row 0 active by clamping
        '{'{-12'sd100, -12'sd50, 12'sd100, -12'sd40, 12'sd0, -12'sd30, 11'd0, 3'd2, 8'h0f},
          1'b0, '0},
        // wholly below screen: last row active
        '{'{12'sd10, 12'sd900, 12'sd300, 12'sd950, 12'sd50, 12'sd1000, 11'd479, 3'd3, 8'h55},
          1'b0, '0},
        // middle row exactly
        '{'{12'sd0, 12'sd0, 12'sd200, 12'sd20, 12'sd0, 12'sd40, 11'd20, 3'd4, 8'h01},
          1'b0, '0},
        // negative left end: rejected
        '{'{-12'sd50, 12'sd0, 12'sd20, 12'sd10, -12'sd50, 12'sd20, 11'd10, 3'd5, 8'h10},
          1'b0, '0},
        // right end off screen: rejected
        '{'{12'sd600, 12'sd0, 12'sd2047, 12'sd10, 12'sd600, 12'sd20, 11'd10, 3'd6, 8'h20},
          1'b0, '0},
        // coordinate extremes
        '{'{-12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047, -12'sd2048, 12'sd2047,
            11'd2047, 3'd0, 8'h00}, 1'b0, '0},
        '{'{12'sd2047, -12'sd2048, -12'sd2048, 12'sd0, 12'sd2047, 12'sd2047,
            11'd0, 3'd7, 8'hff}, 1'b0, '0},
        // equal y pairs exercise the sort
        '{'{12'sd5, 12'sd10, 12'sd50, 12'sd10, 12'sd30, 12'sd60, 11'd10, 3'd1, 8'hc3},
          1'b0, '0},
        '{'{12'sd5, 12'sd60, 12'sd50, 12'sd10, 12'sd30, 12'sd60, 11'd59, 3'd2, 8'h3c},
          1'b0, '0},
        // row outside range
        '{'{12'sd5, 12'sd10, 12'sd50, 12'sd20, 12'sd30, 12'sd30, 11'd31, 3'd3, 8'h99},
          1'b0, '0}
    };

    initial begin
        int mode;
        tri_req_t t;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) send_request(directed[i].t, directed[i].check, directed[i].s);
        end_burst();
        drain_results();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                1: begin write_reg(REG_SCREEN_WIDTH, 32'd2047);
                         write_reg(REG_SCREEN_HEIGHT, 32'd2047);
                         write_reg(REG_PLANE_BIT_COUNTS, 32'hffff_ffff); end
                2: begin write_reg(REG_SCREEN_WIDTH, 32'd1);
                         write_reg(REG_SCREEN_HEIGHT, 32'd1);
                         write_reg(REG_PLANE_BIT_COUNTS, 32'h0); end
                3: begin write_reg(REG_SCREEN_WIDTH, 32'd0);
                         write_reg(REG_SCREEN_HEIGHT, 32'd0); end
                default: if (phase > 3) begin
                    write_reg(REG_SCREEN_WIDTH, $urandom_range(2047, 1));
                    write_reg(REG_SCREEN_HEIGHT, $urandom_range(2047, 1));
                    write_reg(REG_PLANE_BIT_COUNTS, $urandom());
                end
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 65; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 65; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            if (phase == 4) hold_cycles = 200;
            for (int n = 0; n < 50; n++) begin
                mode = $urandom_range(9);
                mode = (mode < 2) ? 0 : (mode < 6) ? 1 : 2;
                t = rand_request(mode);
                send_request(t, 1'b0, '0);
                // pause until everything is back once mid-phase
                if (n == 25 && phase == 5) begin
                    end_burst();
                    while (expected_spans.size() != 0) @(posedge i_clk);
                end
            end
            end_burst();
            drain_results();
        end

        if (errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("testbench failed");
        $finish;
    end

endmodule
